// File: rtl/b64sd_pkg.sv
// ----------------------------------------------------------------------------
// b64sd_pkg: shared types and constants of the Base64 stream decoder
// Status codes, the job record passed from front to back, and the
// character classification helpers.
// ----------------------------------------------------------------------------
package b64sd_pkg;

   // Default depth of the job queue between front and back
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_EXTRA_PAD = 3'd1,
      STATUS_AFTER_PAD = 3'd2,
      STATUS_BAD_CHAR  = 3'd3,
      STATUS_PAD_COUNT = 3'd4,
      STATUS_LONE_CHAR = 3'd5
   } status_type;

   // One job: up to three bytes, emitted from the top byte down
   typedef struct packed {
      logic [23:0] bytes;
      logic [1:0]  last_idx;
      logic        byte_valid;
      status_type  status;
   } job_type;

   // Returns {invalid, sextet}
   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [7:0] d;
      logic [6:0] r;
      d = 8'd0;
      r = 7'h40;
      if (c inside {[8'h41:8'h5A]}) begin
         d = c - 8'h41;
         r = {1'b0, d[5:0]};
      end else if (c inside {[8'h61:8'h7A]}) begin
         d = c - 8'h61 + 8'd26;
         r = {1'b0, d[5:0]};
      end else if (c inside {[8'h30:8'h39]}) begin
         d = c - 8'h30 + 8'd52;
         r = {1'b0, d[5:0]};
      end else if (c == 8'h2B) begin
         r = 7'd62;
      end else if (c == 8'h2F) begin
         r = 7'd63;
      end
      return r;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c inside {8'h20, 8'h0C, 8'h0A, 8'h0D, 8'h09, 8'h0B};
   endfunction

endpackage

// File: rtl/b64sd_front.sv
// ----------------------------------------------------------------------------
// b64sd_front: request intake and classification
// Classifies each character, gathers sextets and padding, tracks the sticky
// error, and pushes one job for every request that produces results.
// ----------------------------------------------------------------------------
module b64sd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_func,
   input  logic [7:0]          req_char,
   output logic                req_ready,
   input  logic                queue_full,
   output logic                push_valid,
   output b64sd_pkg::job_type  push_job
);

   logic [5:0]             held_ff [3];
   logic [1:0]             held_count_ff, held_count_in;
   logic [1:0]             pad_count_ff, pad_count_in;
   b64sd_pkg::status_type  error_ff, error_in;
   logic                   held_we;
   logic [6:0]             lookup;
   logic                   accept;
   b64sd_pkg::status_type  end_code;
   logic [2:0]             fill_sum;

   assign req_ready = !queue_full;
   assign accept    = req_valid && !queue_full;
   assign lookup    = b64sd_pkg::sextet_of(req_char);
   assign fill_sum  = {1'b0, held_count_ff} + {1'b0, pad_count_ff};

   always_comb begin
      end_code = error_ff;
      if (end_code == b64sd_pkg::STATUS_OK && pad_count_ff != 2'd0 && fill_sum != 3'd4) begin
         end_code = b64sd_pkg::STATUS_PAD_COUNT;
      end
      if (end_code == b64sd_pkg::STATUS_OK && held_count_ff == 2'd1) begin
         end_code = b64sd_pkg::STATUS_LONE_CHAR;
      end
   end

   always_comb begin
      held_count_in       = held_count_ff;
      pad_count_in        = pad_count_ff;
      error_in            = error_ff;
      held_we             = 1'b0;
      push_valid          = 1'b0;
      push_job.bytes      = 24'd0;
      push_job.last_idx   = 2'd0;
      push_job.byte_valid = 1'b0;
      push_job.status     = b64sd_pkg::STATUS_OK;
      if (accept) begin
         if (req_func) begin
            // End of message: flush leftovers or report, then clear
            push_valid = 1'b1;
            if (end_code != b64sd_pkg::STATUS_OK) begin
               push_job.status = end_code;
            end else if (held_count_ff == 2'd2) begin
               push_job.bytes      = {held_ff[0], held_ff[1], 12'd0};
               push_job.byte_valid = 1'b1;
            end else if (held_count_ff == 2'd3) begin
               push_job.bytes      = {held_ff[0], held_ff[1], held_ff[2], 6'd0};
               push_job.byte_valid = 1'b1;
               push_job.last_idx   = 2'd1;
            end
            held_count_in = 2'd0;
            pad_count_in  = 2'd0;
            error_in      = b64sd_pkg::STATUS_OK;
         end else if (error_ff != b64sd_pkg::STATUS_OK) begin
            // Drop characters until the end request
         end else if (req_char == b64sd_pkg::PAD_CHAR) begin
            if (pad_count_ff >= 2'd2) begin
               error_in        = b64sd_pkg::STATUS_EXTRA_PAD;
               push_valid      = 1'b1;
               push_job.status = b64sd_pkg::STATUS_EXTRA_PAD;
            end else begin
               pad_count_in = pad_count_ff + 2'd1;
            end
         end else if (pad_count_ff != 2'd0) begin
            error_in        = b64sd_pkg::STATUS_AFTER_PAD;
            push_valid      = 1'b1;
            push_job.status = b64sd_pkg::STATUS_AFTER_PAD;
         end else if (b64sd_pkg::is_space(req_char)) begin
            // Skip whitespace
         end else if (lookup[6]) begin
            error_in        = b64sd_pkg::STATUS_BAD_CHAR;
            push_valid      = 1'b1;
            push_job.status = b64sd_pkg::STATUS_BAD_CHAR;
         end else if (held_count_ff != 2'd3) begin
            held_we       = 1'b1;
            held_count_in = held_count_ff + 2'd1;
         end else begin
            push_valid          = 1'b1;
            push_job.bytes      = {held_ff[0], held_ff[1], held_ff[2], lookup[5:0]};
            push_job.byte_valid = 1'b1;
            push_job.last_idx   = 2'd2;
            held_count_in       = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= 2'd0;
         pad_count_ff  <= 2'd0;
         error_ff      <= b64sd_pkg::STATUS_OK;
      end else begin
         held_count_ff <= held_count_in;
         pad_count_ff  <= pad_count_in;
         error_ff      <= error_in;
      end
   end

   always_ff @(posedge clock) begin
      if (held_we) begin
         held_ff[held_count_ff] <= lookup[5:0];
      end
   end

endmodule

// File: rtl/b64sd_queue.sv
// ----------------------------------------------------------------------------
// b64sd_queue: job queue between front and back
// Small first-in first-out buffer of job records.
// ----------------------------------------------------------------------------
module b64sd_queue #(
   parameter int DEPTH = b64sd_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  b64sd_pkg::job_type  push_job,
   input  logic                pop,
   output b64sd_pkg::job_type  head_job,
   output logic                not_empty,
   output logic                full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   b64sd_pkg::job_type  slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign not_empty = count_ff != '0;
   assign full      = count_ff == FULL_CNT;
   assign head_job  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: rtl/b64sd_back.sv
// ----------------------------------------------------------------------------
// b64sd_back: result sequencer
// Walks the head job into the response register, one byte per unstalled cycle.
// ----------------------------------------------------------------------------
module b64sd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   input  b64sd_pkg::job_type  job,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_byte,
   output logic                rsp_byte_valid,
   output logic [2:0]          rsp_status,
   output logic                rsp_last
);

   logic [1:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff;
   logic        byte_valid_ff;
   logic [2:0]  status_ff;
   logic        last_ff;
   logic        load;
   logic        is_last;
   logic [7:0]  sel_byte;

   assign load    = job_valid && (!valid_ff || rsp_ready);
   assign is_last = idx_ff == job.last_idx;
   assign pop     = load && is_last;

   always_comb begin
      case (idx_ff)
         2'd0:    sel_byte = job.bytes[23:16];
         2'd1:    sel_byte = job.bytes[15:8];
         default: sel_byte = job.bytes[7:0];
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = is_last ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff       <= sel_byte;
         byte_valid_ff <= job.byte_valid;
         status_ff     <= job.status;
         last_ff       <= is_last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_byte       = byte_ff;
   assign rsp_byte_valid = byte_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_last       = last_ff;

endmodule

// File: rtl/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder: streaming Base64 text decoder
// Takes one text character or end-of-message marker per request and emits
// decoded bytes and status results.
// ----------------------------------------------------------------------------
// Feed one character per request with req_tuser low; raise req_tuser to end
// the message. Letters of the standard alphabet are gathered four at a time
// and each full group gives three byte results; whitespace is skipped and up
// to two '=' pads are counted. The end request flushes one or two leftover
// bytes, or reports a padding error, a lone character or the sticky error,
// and always clears the decoder. A request that hits an error gives one
// result with the error code and rsp_tlast set; later characters give
// nothing until the end request. The front accepts one request per cycle
// while the job queue (QUEUE_DEPTH entries) has room; the back emits one
// result per cycle while rsp_tready is high, and with rsp_tready held high
// typical text streams at one character per cycle. The first result of a
// request passes through the job queue and then the response register
// before it is presented on the response port.
// rsp_tuser carries byte_valid in bit 0 and the status code in bits 3:1.
// ----------------------------------------------------------------------------
module base64_stream_decoder #(
   parameter int QUEUE_DEPTH = b64sd_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   input  logic        req_tuser,   // [0] func (1 ends the message)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic [3:0]  rsp_tuser,   // [0] byte_valid, [3:1] status
   output logic        rsp_tlast    // final result of its request
);

   logic                queue_full;
   logic                push_valid;
   b64sd_pkg::job_type  push_job;
   b64sd_pkg::job_type  head_job;
   logic                queue_not_empty;
   logic                pop;
   logic                rsp_byte_valid;
   logic [2:0]          rsp_status;

   // Classify requests and build jobs
   b64sd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_func   (req_tuser),
      .req_char   (req_tdata),
      .req_ready  (req_tready),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   // Decouple intake from result delivery
   b64sd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_job  (push_job),
      .pop       (pop),
      .head_job  (head_job),
      .not_empty (queue_not_empty),
      .full      (queue_full)
   );

   // Emit results one per cycle while rsp_tready is high
   b64sd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (queue_not_empty),
      .job            (head_job),
      .pop            (pop),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_byte       (rsp_tdata),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_tlast)
   );

   assign rsp_tuser = {rsp_status, rsp_byte_valid};

endmodule

// File: rtl/b64sd_checker.sv
// ----------------------------------------------------------------------------
// b64sd_checker: port-level checks of the Base64 stream decoder
// Watches the response channel for consistency of its fields over time.
// ----------------------------------------------------------------------------
module b64sd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic [3:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // An error result carries no byte and closes its request
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3:1] != b64sd_pkg::STATUS_OK |->
         !rsp_tuser[0] && rsp_tlast)
      else $error("error result without last or with data");

   // A result without a byte shows zero data and ends its request
   a_nobyte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 8'd0 && rsp_tlast)
      else $error("empty result with nonzero data or not last");

   // Status codes stay within the defined set
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[3:1] <= b64sd_pkg::STATUS_LONE_CHAR)
      else $error("undefined status code");

endmodule

bind base64_stream_decoder b64sd_checker u_b64sd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// File: tb/sv/tb_base64_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_stream_decoder: self-checking bench for the Base64 stream decoder
// Drives text characters and end-of-message requests, predicts every decoded
// byte and status result, and checks each response field by field, in order.
// ----------------------------------------------------------------------------
module tb_base64_stream_decoder;

   localparam logic FUNC_CHAR  = 1'b0;
   localparam logic FUNC_END   = 1'b1;
   localparam int   TAIL_ITEMS = 40;      // no idling once fewer than this many requests remain
   localparam int   RANDOM_ITEMS = 110;

   // One pending request for the driver
   typedef struct {
      logic       is_end;
      logic [7:0] char_in;
      bit         drain_first;   // hold off until every expected result is in
   } text_item_type;

   // One expected response
   typedef struct {
      logic [7:0]            out_byte;
      logic                  byte_valid;
      b64sd_pkg::status_type status;
      logic                  last;
   } decoded_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;     // [7:0] char_in
   logic       req_tuser = 1'b0;   // [0] func
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;          // [7:0] out_byte
   logic [3:0] rsp_tuser;          // [0] byte_valid, [3:1] status
   logic       rsp_tlast;

   text_item_type text_q[$];
   decoded_type   decoded_q[$];

   // Predictor state
   logic [5:0]            held[3];
   int                    held_cnt;
   int                    pads_seen;
   b64sd_pkg::status_type sticky_err;

   int  mismatches;
   int  n_requests, n_messages, n_bytes, n_status;
   int  random_items;
   bit  hold_next;
   int  send_gap, recv_gap;

   base64_stream_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Alphabet helpers
   // ------------------------------------------------------------------------

   // Return {not_a_letter, value} for one text byte
   function automatic logic [6:0] alphabet_index(logic [7:0] c);
      if (c >= "A" && c <= "Z") return {1'b0, 6'(c - "A")};
      if (c >= "a" && c <= "z") return {1'b0, 6'(c - "a" + 8'd26)};
      if (c >= "0" && c <= "9") return {1'b0, 6'(c - "0" + 8'd52)};
      if (c == "+") return {1'b0, 6'd62};
      if (c == "/") return {1'b0, 6'd63};
      return 7'h40;
   endfunction

   function automatic bit is_blank(logic [7:0] c);
      return c == 8'h20 || c == 8'h0C || c == 8'h0A || c == 8'h0D || c == 8'h09 || c == 8'h0B;
   endfunction

   function automatic logic [7:0] letter_of(logic [5:0] v);
      if (v < 26) return 8'("A" + v);
      if (v < 52) return 8'("a" + v - 26);
      if (v < 62) return 8'("0" + v - 52);
      if (v == 62) return "+";
      return "/";
   endfunction

   function automatic logic [7:0] blank_char();
      logic [7:0] set[6];
      set = '{8'h20, 8'h0C, 8'h0A, 8'h0D, 8'h09, 8'h0B};
      return set[$urandom_range(0, 5)];
   endfunction

   // ------------------------------------------------------------------------
   // Predictor: advance the decoder state for one accepted request and queue
   // the responses it must produce.
   // ------------------------------------------------------------------------
   function automatic void expect_result(logic [7:0] b, logic v,
                                         b64sd_pkg::status_type s, logic l);
      decoded_type d;
      d.out_byte = b;
      d.byte_valid = v;
      d.status = s;
      d.last = l;
      decoded_q.push_back(d);
      if (v) n_bytes++;
      if (s != b64sd_pkg::STATUS_OK) n_status++;
   endfunction

   function automatic void flag_error(b64sd_pkg::status_type s);
      sticky_err = s;
      expect_result(8'h00, 1'b0, s, 1'b1);
   endfunction

   function automatic void decode_request(logic is_end, logic [7:0] c);
      logic [6:0]            idx;
      logic [23:0]           bits;
      b64sd_pkg::status_type code;
      n_requests++;
      if (is_end == FUNC_END) begin
         n_messages++;
         code = sticky_err;
         if (code == b64sd_pkg::STATUS_OK && pads_seen != 0 && held_cnt + pads_seen != 4)
            code = b64sd_pkg::STATUS_PAD_COUNT;
         if (code == b64sd_pkg::STATUS_OK && held_cnt == 1)
            code = b64sd_pkg::STATUS_LONE_CHAR;
         if (code != b64sd_pkg::STATUS_OK) begin
            expect_result(8'h00, 1'b0, code, 1'b1);
         end else if (held_cnt == 2) begin
            bits = {held[0], held[1], 12'h000};
            expect_result(bits[23:16], 1'b1, b64sd_pkg::STATUS_OK, 1'b1);
         end else if (held_cnt == 3) begin
            bits = {held[0], held[1], held[2], 6'h00};
            expect_result(bits[23:16], 1'b1, b64sd_pkg::STATUS_OK, 1'b0);
            expect_result(bits[15:8], 1'b1, b64sd_pkg::STATUS_OK, 1'b1);
         end else begin
            expect_result(8'h00, 1'b0, b64sd_pkg::STATUS_OK, 1'b1);
         end
         // an end request always clears the decoder
         held_cnt = 0;
         pads_seen = 0;
         sticky_err = b64sd_pkg::STATUS_OK;
         return;
      end
      // characters after an error are dropped silently
      if (sticky_err != b64sd_pkg::STATUS_OK) return;
      if (c == b64sd_pkg::PAD_CHAR) begin
         if (pads_seen >= 2) flag_error(b64sd_pkg::STATUS_EXTRA_PAD);
         else pads_seen++;
         return;
      end
      if (pads_seen != 0) begin
         flag_error(b64sd_pkg::STATUS_AFTER_PAD);
         return;
      end
      if (is_blank(c)) return;
      idx = alphabet_index(c);
      if (idx[6]) begin
         flag_error(b64sd_pkg::STATUS_BAD_CHAR);
         return;
      end
      if (held_cnt < 3) begin
         held[held_cnt] = idx[5:0];
         held_cnt++;
         return;
      end
      bits = {held[0], held[1], held[2], idx[5:0]};
      expect_result(bits[23:16], 1'b1, b64sd_pkg::STATUS_OK, 1'b0);
      expect_result(bits[15:8], 1'b1, b64sd_pkg::STATUS_OK, 1'b0);
      expect_result(bits[7:0], 1'b1, b64sd_pkg::STATUS_OK, 1'b1);
      held_cnt = 0;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus builders
   // ------------------------------------------------------------------------
   function automatic void push_item(logic is_end, logic [7:0] c);
      text_item_type t;
      t.is_end = is_end;
      t.char_in = c;
      t.drain_first = hold_next;
      hold_next = 1'b0;
      text_q.push_back(t);
      if (is_end == FUNC_END || !is_blank(c)) random_items++;
   endfunction

   function automatic void push_char(logic [7:0] c);
      push_item(FUNC_CHAR, c);
   endfunction

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i]);
   endfunction

   function automatic void push_end();
      // char_in is ignored on an end request; fill it with noise anyway
      push_item(FUNC_END, 8'($urandom_range(0, 255)));
   endfunction

   // Encode a random payload, mostly well formed, sometimes broken
   function automatic void push_message();
      int          nbytes, kind, k;
      logic [23:0] group;
      bit          pad_on;
      nbytes = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
      kind = $urandom_range(0, 9);   // 0..6 clean, 7 stray byte, 8 extra pads, 9 extra letter
      pad_on = $urandom_range(0, 3) != 0;
      for (int i = 0; i < nbytes; i += 3) begin
         k = (nbytes - i >= 3) ? 3 : nbytes - i;
         group = 24'($urandom);
         for (int j = 0; j <= k; j++) begin
            if ($urandom_range(0, 7) == 0) push_char(blank_char());
            push_char(letter_of(group[23 - 6 * j -: 6]));
         end
         if (k < 3 && pad_on)
            for (int p = k; p < 3; p++) push_char(b64sd_pkg::PAD_CHAR);
      end
      case (kind)
         7: push_char(8'($urandom_range(0, 255)));
         8: begin
            k = $urandom_range(1, 3);
            for (int p = 0; p < k; p++) push_char(b64sd_pkg::PAD_CHAR);
         end
         9: push_char(letter_of(6'($urandom_range(0, 63))));
         default: ;
      endcase
      push_end();
   endfunction

   // ------------------------------------------------------------------------
   // Driver: present queued requests, hold on backpressure, idle in bursts
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      logic          send;
      text_item_type t;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) decode_request(req_tuser, req_tdata);
         send = 1'b0;
         if (req_tvalid && !req_tready) begin
            send = 1'b1;   // hold the current request
         end else if (send_gap > 0) begin
            send_gap--;
         end else if (text_q.size() >= TAIL_ITEMS && $urandom_range(0, 11) == 0) begin
            send_gap = $urandom_range(0, 6);   // start an idle burst
         end else if (text_q.size() != 0 &&
                      !(text_q[0].drain_first && decoded_q.size() != 0)) begin
            t = text_q.pop_front();
            req_tdata <= t.char_in;
            req_tuser <= t.is_end;
            send = 1'b1;
         end
         req_tvalid <= send;
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: check each response against the oldest expectation; stall
   // rsp_tready in bursts
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_responses
      decoded_type d;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_q.size() == 0) begin
               $error("unexpected response: out_byte %0h tuser %0h tlast %0b",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               mismatches++;
            end else begin
               d = decoded_q.pop_front();
               if (rsp_tdata !== d.out_byte) begin
                  $error("out_byte: expected %0h, got %0h", d.out_byte, rsp_tdata);
                  mismatches++;
               end
               if (rsp_tuser[0] !== d.byte_valid) begin
                  $error("byte_valid: expected %0b, got %0b", d.byte_valid, rsp_tuser[0]);
                  mismatches++;
               end
               if (rsp_tuser[3:1] !== d.status) begin
                  $error("status: expected %0d, got %0d", d.status, rsp_tuser[3:1]);
                  mismatches++;
               end
               if (rsp_tlast !== d.last) begin
                  $error("last: expected %0b, got %0b", d.last, rsp_tlast);
                  mismatches++;
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else if (text_q.size() >= TAIL_ITEMS && $urandom_range(0, 9) == 0) begin
            recv_gap = $urandom_range(0, 6);   // start a stall burst
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sequence: build all stimulus, release reset, wait for drain, report
   // ------------------------------------------------------------------------
   initial begin
      held_cnt = 0;
      pads_seen = 0;
      sticky_err = b64sd_pkg::STATUS_OK;
      hold_next = 1'b0;

      // Directed: empty end, alphabet extremes with blanks, both pad forms,
      // lone character, short padding, third pad, blank after a pad, high byte
      push_end();
      push_text("A");
      push_char(" ");
      push_text("z+/");
      push_text("09");
      push_char(8'h0D);
      push_char(b64sd_pkg::PAD_CHAR);
      push_char(b64sd_pkg::PAD_CHAR);
      push_end();
      push_text("QUJ");
      push_char(b64sd_pkg::PAD_CHAR);
      push_end();
      push_text("Q");
      push_end();
      push_text("QU");
      push_char(b64sd_pkg::PAD_CHAR);
      push_end();
      for (int i = 0; i < 3; i++) push_char(b64sd_pkg::PAD_CHAR);
      push_end();
      push_char(b64sd_pkg::PAD_CHAR);
      push_char(8'h09);
      push_end();
      push_char(8'h80);
      push_end();

      // Random messages; the first one waits for the pipeline to empty
      random_items = 0;
      hold_next = 1'b1;
      while (random_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) == 0) hold_next = 1'b1;
         push_message();
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // wait until every request is accepted and every response is in
      while (text_q.size() != 0 || req_tvalid) @(posedge clock);
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      $display("Ran %0d requests over %0d messages: %0d data bytes and %0d error results.",
               n_requests, n_messages, n_bytes, n_status);
      if (mismatches == 0 && decoded_q.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Watchdog far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
